[hw/rtl/gbs_pkg.sv]
// gbs_pkg: types and constants shared by the greedy box suppression block
// holds payload structs, queue job and store entry layouts, back-end state enum
// no dependencies
package gbs_pkg;

  // fixed field widths
  localparam int COORD_W = 12;
  localparam int AREA_W  = 24;
  localparam int INDEX_W = 12;
  localparam int THR_W   = 9;
  localparam int OVL_W   = COORD_W + 3;
  localparam int UNI_W   = AREA_W + 1;
  localparam int PROD_W  = UNI_W + THR_W;
  localparam int Q_DEPTH = 2;
  localparam logic [THR_W-1:0] THR_RESET = 9'd128;

  // input transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [COORD_W-1:0]        box_width;
    logic [COORD_W-1:0]        box_height;
    logic                      last_box;
  } gbs_in_t;

  // result transaction
  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] box_index;
    logic               store_overflow;
    logic               set_done;
  } gbs_out_t;

  // classified box handed from front to back
  typedef struct packed {
    gbs_in_t            box;
    logic [AREA_W-1:0]  area;
    logic [INDEX_W-1:0] index;
  } gbs_job_t;

  // one kept box in the store
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [COORD_W-1:0]        width;
    logic [COORD_W-1:0]        height;
    logic [AREA_W-1:0]         area;
  } gbs_entry_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } gbs_qstat_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } gbs_state_t;

endpackage

[hw/rtl/gbs_front.sv]
// gbs_front: accepts input transactions, computes box area and set position
// depends on gbs_pkg; pushes jobs into gbs_queue
module gbs_front
  import gbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  gbs_in_t    in_data,
  input  gbs_qstat_t q_stat,
  output logic       push,
  output gbs_job_t   job
);

  logic [INDEX_W-1:0] pos_r;
  logic [INDEX_W-1:0] pos_nxt;

  // accept whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // classify: area and position within the set
  always_comb begin
    job.box   = in_data;
    job.area  = AREA_W'(in_data.box_width) * AREA_W'(in_data.box_height);
    job.index = pos_r;
  end

  // set position wraps naturally, clears after the last box
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_data.last_box ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[hw/rtl/gbs_queue.sv]
// gbs_queue: short job queue decoupling front and back
// depends on gbs_pkg
module gbs_queue
  import gbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gbs_job_t   push_job,
  input  logic       pop,
  output gbs_job_t   head,
  output gbs_qstat_t q_stat
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  gbs_job_t         slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign q_stat.full  = (fill_r == CNT_W'(Q_DEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign head         = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/gbs_back.sv]
// gbs_back: compares each job against the kept-box store, one entry per cycle
// depends on gbs_pkg; holds the store memory and the result register
module gbs_back
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [THR_W-1:0] thr,
  input  gbs_job_t         head,
  input  gbs_qstat_t       q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output gbs_out_t         out_data
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);

  gbs_state_t state_r, state_nxt;
  gbs_job_t   cur_r;
  gbs_entry_t mem [MAX_KEPT];
  gbs_entry_t rd_q_r;
  gbs_entry_t wr_entry;
  gbs_out_t   out_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  issue_r;
  logic              rd_v_r;
  logic              s2_v_r;
  logic              supp_r;
  logic [AREA_W-1:0] inter_r;
  logic [AREA_W-1:0] karea_r;

  logic issue;
  logic finish;
  logic keep_w;
  logic full_w;
  logic wr_en;

  // overlap terms
  logic signed [OVL_W-1:0] a_l, a_t, a_r, a_b;
  logic signed [OVL_W-1:0] b_l, b_t, b_r, b_b;
  logic signed [OVL_W-1:0] ow, oh;
  logic [AREA_W-1:0]       inter_w;
  logic [UNI_W-1:0]        uni_w;
  logic [PROD_W-1:0]       lhs_w;
  logic [PROD_W-1:0]       rhs_w;
  logic                    hit_w;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!(issue_r < count_r)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!rd_v_r && !s2_v_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop    = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      ST_IDLE:  pop    = !q_stat.empty;
      ST_SCAN:  issue  = issue_r < count_r;
      ST_FLUSH: ;
      ST_DONE:  finish = !out_valid || !out_stall;
      default:  ;
    endcase
  end

  // stage b: intersection of current box with the entry read last cycle
  always_comb begin
    a_l = OVL_W'(cur_r.box.box_left);
    a_t = OVL_W'(cur_r.box.box_top);
    a_r = a_l + $signed({3'b000, cur_r.box.box_width});
    a_b = a_t + $signed({3'b000, cur_r.box.box_height});
    b_l = OVL_W'(rd_q_r.left);
    b_t = OVL_W'(rd_q_r.top);
    b_r = b_l + $signed({3'b000, rd_q_r.width});
    b_b = b_t + $signed({3'b000, rd_q_r.height});
    ow  = ((a_r < b_r) ? a_r : b_r) - ((a_l > b_l) ? a_l : b_l);
    oh  = ((a_b < b_b) ? a_b : b_b) - ((a_t > b_t) ? a_t : b_t);
    if (ow > 0 && oh > 0) begin
      inter_w = AREA_W'(ow[COORD_W-1:0]) * AREA_W'(oh[COORD_W-1:0]);
    end else begin
      inter_w = '0;
    end
  end

  // stage c: exact test inter*256 > thr*union
  always_comb begin
    uni_w = UNI_W'(cur_r.area) + UNI_W'(karea_r) - UNI_W'(inter_r);
    lhs_w = PROD_W'({inter_r, 8'b0});
    rhs_w = PROD_W'(thr) * PROD_W'(uni_w);
    hit_w = lhs_w > rhs_w;
  end

  // store write and result decision
  always_comb begin
    keep_w         = !supp_r;
    full_w         = count_r == CNT_W'(MAX_KEPT);
    wr_en          = finish && keep_w && !full_w;
    wr_entry.left   = cur_r.box.box_left;
    wr_entry.top    = cur_r.box.box_top;
    wr_entry.width  = cur_r.box.box_width;
    wr_entry.height = cur_r.box.box_height;
    wr_entry.area   = cur_r.area;
    count_nxt      = cur_r.box.last_box ? '0 : count_r + CNT_W'(wr_en);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      issue_r   <= '0;
      rd_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      supp_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      s2_v_r  <= rd_v_r;
      if (pop) begin
        issue_r <= '0;
        supp_r  <= 1'b0;
      end else begin
        if (issue) issue_r <= issue_r + 1'b1;
        if (s2_v_r && hit_w) supp_r <= 1'b1;
      end
      if (finish) begin
        count_r   <= count_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    inter_r <= inter_w;
    karea_r <= rd_q_r.area;
    if (finish) begin
      out_r.keep           <= keep_w;
      out_r.box_index      <= cur_r.index;
      out_r.store_overflow <= keep_w && full_w;
      out_r.set_done       <= cur_r.box.last_box;
    end
  end

  // kept-box store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IDX_W-1:0]] <= wr_entry;
    rd_q_r <= mem[issue_r[IDX_W-1:0]];
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> issue_r <= count_r)
    else $error("issued reads beyond kept count");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !rd_v_r && !s2_v_r)
    else $error("result decided with compares still in flight");

  a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !cur_r.box.last_box |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("kept count did not advance on store write");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    finish && cur_r.box.last_box |=> count_r == '0)
    else $error("store not cleared after last box");

  a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_r.store_overflow |-> out_r.keep)
    else $error("overflow flagged on suppressed box");
`endif

endmodule

[hw/rtl/greedy_box_suppression.sv]
// greedy_box_suppression: top level of the greedy box suppression block
// depends on gbs_pkg, gbs_front, gbs_queue, gbs_back; holds the threshold register
//
// Usage: boxes enter on in_valid/in_stall/in_data sorted by falling score,
// the set closed by last_box. Each input transaction gives exactly one result
// transaction on out_valid/out_stall/out_data, in order: keep, the box's
// position in its set, store_overflow for a kept box that found the store
// full, and set_done echoing last_box.
// The threshold register is loaded through cfg_wr_en/cfg_wr_data; the user
// must load it only while idle, which the block itself does not enforce.
// Timing: an accepted box enters the queue at its accepting edge; the back
// reads one kept entry per cycle through a three-stage compare pipeline, a
// rate set by the store's single read port. A box is popped, compared against
// every kept entry, and its result registered once the compare pipeline has
// drained. The two-entry queue lets the next boxes be accepted meanwhile.
// Reset: kept count and set position return to zero, threshold to 128; the
// store needs no clearing since only entries below the kept count are compared.
// Stall: a result held by out_stall stays in the output register; the back
// waits with its next result, the queue fills and in_stall rises.
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gbs_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gbs_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  logic [THR_W-1:0] thr_r;
  gbs_qstat_t       q_stat;
  gbs_job_t         push_job;
  gbs_job_t         head;
  logic             push;
  logic             pop;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  gbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  gbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gbs_back #(
    .MAX_KEPT (MAX_KEPT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr_r),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
